/* rtl/mkdg_pkg.sv */
package mkdg_pkg;

  localparam int NUM_KEYS = 4;
  localparam int KeyW = 2;
  localparam int CountW = $clog2(NUM_KEYS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int CfgDataW = 16;

  localparam logic [15:0] HOLD_MS_RESET = 16'd30;
  localparam logic [2:0] VETO_COUNT_RESET = 3'd3;

  typedef enum logic {
    CFG_HOLD_MS = 1'b0,
    CFG_VETO_COUNT = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [3:0] pin_levels;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0] key_index;
    logic pressed;
    logic [3:0] pressed_mask;
    logic last_event;
  } out_t;

  // One queued tick: which keys commit and the level each commits to.
  typedef struct packed {
    logic [NUM_KEYS-1:0] commit_mask;
    logic [NUM_KEYS-1:0] levels;
  } job_t;

endpackage

/* rtl/mkdg_front.sv */
module mkdg_front import mkdg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t in_i,
  input  logic [15:0] hold_ms_i,
  input  logic [2:0] veto_count_i,
  output logic job_valid_o,
  input  logic job_ready_i,
  output job_t job_o
);

  localparam int CmpW = (CountW > 3) ? CountW : 3;

  logic [NUM_KEYS-1:0] cand_q, cand_d;
  logic [NUM_KEYS-1:0] comm_q, comm_d;
  logic [31:0] since_q [NUM_KEYS];
  logic [31:0] since_d [NUM_KEYS];
  logic [31:0] elapsed [NUM_KEYS];
  logic [NUM_KEYS-1:0] commit;
  logic [NUM_KEYS-1:0] levels;
  logic [CountW-1:0] n_commit;
  logic veto;
  logic accept;

  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      levels[i] = (i < 4) ? in_i.pin_levels[i] : 1'b0;
      cand_d[i] = levels[i];
      since_d[i] = (levels[i] != cand_q[i]) ? in_i.now_ms : since_q[i];
      elapsed[i] = in_i.now_ms - since_d[i];
      commit[i] = (levels[i] != comm_q[i]) && (elapsed[i] >= {16'b0, hold_ms_i});
      comm_d[i] = commit[i] ? levels[i] : comm_q[i];
    end
  end

  assign n_commit = CountW'($countones(commit));
  assign veto = (CmpW'(veto_count_i) <= CmpW'(n_commit));

  assign in_ready_o = job_ready_i;
  assign accept = in_valid_i && in_ready_o;
  assign job_valid_o = in_valid_i && !veto && (commit != '0);
  assign job_o.commit_mask = commit;
  assign job_o.levels = levels;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '1;
      comm_q <= '1;
      for (int i = 0; i < NUM_KEYS; i++) begin
        since_q[i] <= '0;
      end
    end else if (accept) begin
      cand_q <= cand_d;
      comm_q <= comm_d;
      for (int i = 0; i < NUM_KEYS; i++) begin
        since_q[i] <= since_d[i];
      end
    end
  end

endmodule

/* rtl/mkdg_fifo.sv */
module mkdg_fifo import mkdg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  job_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output job_t out_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  job_t mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_ready_o = (cnt_q != CntW'(QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_o = mem_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/mkdg_back.sv */
module mkdg_back import mkdg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  output logic job_ready_o,
  input  job_t job_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic busy_q, busy_d;
  logic [NUM_KEYS-1:0] rem_q, rem_d;
  logic [NUM_KEYS-1:0] lvl_q, lvl_d;
  logic [3:0] mask_q, mask_d;
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;
  logic emit;
  logic last;
  logic [KeyW-1:0] sel_idx;
  logic [NUM_KEYS-1:0] sel_bit;
  logic [NUM_KEYS-1:0] rem_left;
  logic [3:0] mask_bit;
  logic down;

  always_comb begin
    sel_idx = '0;
    sel_bit = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        sel_idx = KeyW'(i);
        sel_bit = '0;
        sel_bit[i] = 1'b1;
      end
    end
  end

  assign emit = busy_q && (!out_valid_q || out_ready_i);
  assign rem_left = rem_q & ~sel_bit;
  assign last = (rem_left == '0);
  assign job_ready_o = !busy_q || (emit && last);
  assign down = !lvl_q[sel_idx];
  assign mask_bit = 4'(1) << sel_idx;

  always_comb begin
    busy_d = busy_q;
    rem_d = rem_q;
    lvl_d = lvl_q;
    mask_d = mask_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    if (emit) begin
      mask_d = down ? (mask_q | mask_bit) : (mask_q & ~mask_bit);
      out_valid_d = 1'b1;
      out_d.key_index = sel_idx;
      out_d.pressed = down;
      out_d.pressed_mask = mask_d;
      out_d.last_event = last;
      rem_d = rem_left;
      busy_d = !last;
    end
    if (job_valid_i && job_ready_o) begin
      busy_d = 1'b1;
      rem_d = job_i.commit_mask;
      lvl_d = job_i.levels;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mask_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      mask_q <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lvl_q <= lvl_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

endmodule

/* rtl/multi_key_debounce_glitch_veto_top.sv */
// Debounces four active-low keys with a confirm-hold time and absorbs supply glitches: when
// veto_count or more keys commit on the same poll tick, they commit without any event.
// The front end takes one poll tick per cycle while its two-entry queue has room and
// updates the per-key debounce state at once; the event engine behind the queue sends one
// down or up event per cycle, in ascending key order, so a tick that commits k keys, one to
// four, keeps it busy for k events. A result waiting in the output register stalls the event
// engine; the front end keeps taking ticks until the queue is full.
module multi_key_debounce_glitch_veto_top import mkdg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o,
  input  logic cfg_we_i,
  input  logic cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [15:0] hold_ms_q;
  logic [2:0] veto_count_q;
  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  job_t push_job, pop_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ms_q <= HOLD_MS_RESET;
      veto_count_q <= VETO_COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_HOLD_MS: hold_ms_q <= cfg_data_i[15:0];
        CFG_VETO_COUNT: veto_count_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  mkdg_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_i,
    .hold_ms_i(hold_ms_q),
    .veto_count_i(veto_count_q),
    .job_valid_o(push_valid),
    .job_ready_i(push_ready),
    .job_o(push_job)
  );

  mkdg_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .in_valid_i(push_valid),
    .in_ready_o(push_ready),
    .in_i(push_job),
    .out_valid_o(pop_valid),
    .out_ready_i(pop_ready),
    .out_o(pop_job)
  );

  mkdg_back u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i(pop_valid),
    .job_ready_o(pop_ready),
    .job_i(pop_job),
    .out_valid_o,
    .out_ready_i,
    .out_o
  );

  a_mask_matches_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.pressed == out_o.pressed_mask[out_o.key_index]))
    else $error("event mask disagrees with event direction");

  a_no_lost_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && push_valid) |-> push_ready)
    else $error("tick with events accepted while queue full");

  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid |-> (pop_job.commit_mask != '0))
    else $error("queued tick carries no commits");

endmodule
